// ===== hw/rtl/psgte_pkg.sv =====
package psgte_pkg;

    // Bus request kinds.
    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_TICK  = 2'd2,
        CMD_ACK   = 2'd3
    } t_command;

    // Bus ports.
    typedef enum logic [1:0] {
        PORT_SELECT = 2'd0,
        PORT_DATA   = 2'd1,
        PORT_GPIO_A = 2'd2,
        PORT_GPIO_B = 2'd3
    } t_port;

    localparam int NUM_REGS  = 16;
    localparam int NUM_TONES = 3;

    // Register file indexes with a fixed meaning.
    localparam logic [3:0] REG_TONE_LAST   = 4'd5;
    localparam logic [3:0] REG_ENV_MIRROR  = 4'd8;
    localparam logic [3:0] REG_ENV_LO      = 4'd11;
    localparam logic [3:0] REG_ENV_HI      = 4'd12;
    localparam logic [3:0] REG_GPIO_A_MASK = 4'd14;
    localparam logic [3:0] REG_GPIO_B_MASK = 4'd15;

    localparam int         IRQ_DATA_BIT = 7;
    localparam logic [3:0] ENV_TOP      = 4'hF;

endpackage

// ===== hw/rtl/psg_tone_envelope_registers.sv =====
// Channel   | Direction | Handshake         | Payload
// ----------+-----------+-------------------+---------------------------------------------
// request   | in        | i_valid / o_ready | i_command, i_port, i_write_data
// result    | out       | o_valid / i_ready | o_read_data, o_irq_active, o_tone_a..c,
//           |           |                   | o_env_level
//
// Every accepted request is executed in the cycle it is accepted, and its result is
// held in the output register from the next cycle on, so one request is taken per cycle.
// The single result register sets that figure: the block takes a new request whenever
// the register is empty or its content is being taken in the same cycle.
// A stall on the result side holds the result and deasserts o_ready until it is taken.
// Reset is synchronous and active low; it clears the register file, the select, the
// GPIO latches and the interrupt, loads each counter with one and the envelope with 15.
module psg_tone_envelope_registers
    import psgte_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_command,
    input  logic [1:0] i_port,
    input  logic [7:0] i_write_data,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_read_data,
    output logic       o_irq_active,
    output logic       o_tone_a,
    output logic       o_tone_b,
    output logic       o_tone_c,
    output logic [3:0] o_env_level
);

    // Architectural state.
    logic [7:0]  r_reg_file   [NUM_REGS];
    logic [3:0]  r_reg_index;
    logic [7:0]  r_gpio_a;
    logic [7:0]  r_gpio_b;
    logic [11:0] r_tone_count [NUM_TONES];
    logic [2:0]  r_tone_bit;
    logic [15:0] r_env_count;
    logic [3:0]  r_env_value;
    logic        r_irq;

    // Next-state values.
    logic [7:0]  n_reg_file   [NUM_REGS];
    logic [3:0]  n_reg_index;
    logic [7:0]  n_gpio_a;
    logic [7:0]  n_gpio_b;
    logic [11:0] n_tone_count [NUM_TONES];
    logic [2:0]  n_tone_bit;
    logic [15:0] n_env_count;
    logic [3:0]  n_env_value;
    logic        n_irq;
    logic [7:0]  n_read_data;

    // Result register.
    logic        r_out_valid;
    logic [7:0]  r_read_data;
    logic        r_irq_active;
    logic [2:0]  r_tone_out;
    logic [3:0]  r_env_level;

    logic        accept;
    logic        restart;
    logic [11:0] tone_reload [NUM_TONES];
    logic [11:0] tone_dec    [NUM_TONES];
    logic [15:0] env_period;
    logic [15:0] env_dec;

    assign o_ready = !r_out_valid || i_ready;
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_reg_file  = r_reg_file;
        n_reg_index = r_reg_index;
        n_gpio_a    = r_gpio_a;
        n_gpio_b    = r_gpio_b;
        n_irq       = r_irq;
        n_read_data = 8'h00;
        restart     = 1'b0;

        case (t_command'(i_command))
            CMD_READ: begin
                case (t_port'(i_port))
                    PORT_SELECT: n_read_data = {4'h0, r_reg_index};
                    PORT_DATA:   n_read_data = r_reg_file[r_reg_index];
                    PORT_GPIO_A: n_read_data = r_gpio_a & r_reg_file[REG_GPIO_A_MASK];
                    PORT_GPIO_B: n_read_data = r_gpio_b & r_reg_file[REG_GPIO_B_MASK];
                    default:     n_read_data = 8'h00;
                endcase
            end
            CMD_WRITE: begin
                case (t_port'(i_port))
                    PORT_SELECT: n_reg_index = i_write_data[3:0];
                    PORT_DATA: begin
                        n_reg_file[r_reg_index] = i_write_data;
                        // Any tone or envelope period write restarts every timer.
                        restart = (r_reg_index <= REG_TONE_LAST) ||
                                  (r_reg_index == REG_ENV_LO) ||
                                  (r_reg_index == REG_ENV_HI);
                    end
                    PORT_GPIO_A: n_gpio_a = i_write_data;
                    PORT_GPIO_B: n_gpio_b = i_write_data;
                    default:     n_gpio_b = r_gpio_b;
                endcase
                if (i_write_data[IRQ_DATA_BIT]) begin
                    n_irq = 1'b1;
                end
            end
            CMD_ACK: n_irq = 1'b0;
            default: n_irq = r_irq;
        endcase

        // Periods come from the register file as it stands after this request's write;
        // a period of zero counts as one.
        for (int ch = 0; ch < NUM_TONES; ch++) begin
            tone_reload[ch] = {n_reg_file[2 * ch + 1][3:0], n_reg_file[2 * ch]};
            if (tone_reload[ch] == 12'd0) begin
                tone_reload[ch] = 12'd1;
            end
        end
        env_period = {n_reg_file[REG_ENV_HI], n_reg_file[REG_ENV_LO]};
        if (env_period == 16'd0) begin
            env_period = 16'd1;
        end

        n_tone_count = r_tone_count;
        n_tone_bit   = r_tone_bit;
        n_env_count  = r_env_count;
        n_env_value  = r_env_value;

        for (int ch = 0; ch < NUM_TONES; ch++) begin
            tone_dec[ch] = (r_tone_count[ch] != 12'd0) ? r_tone_count[ch] - 12'd1 : 12'd0;
        end
        env_dec = (r_env_count != 16'd0) ? r_env_count - 16'd1 : 16'd0;

        if (restart) begin
            n_tone_count = tone_reload;
            n_tone_bit   = 3'b000;
            n_env_count  = env_period;
            n_env_value  = ENV_TOP;
        end else if (t_command'(i_command) == CMD_TICK) begin
            // Each tone counter toggles its level and reloads when it runs out.
            for (int ch = 0; ch < NUM_TONES; ch++) begin
                if (tone_dec[ch] == 12'd0) begin
                    n_tone_bit[ch]   = !r_tone_bit[ch];
                    n_tone_count[ch] = tone_reload[ch];
                end else begin
                    n_tone_count[ch] = tone_dec[ch];
                end
            end
            // The envelope steps down on expiry and wraps to the top with an interrupt.
            if (env_dec == 16'd0) begin
                n_env_count = env_period;
                if (r_env_value != 4'd0) begin
                    n_env_value = r_env_value - 4'd1;
                end else begin
                    n_env_value = ENV_TOP;
                    n_irq       = 1'b1;
                end
            end else begin
                n_env_count = env_dec;
            end
            n_reg_file[REG_ENV_MIRROR] = {r_reg_file[REG_ENV_MIRROR][7:4], n_env_value};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                r_reg_file[i] <= 8'h00;
            end
            r_reg_index <= 4'd0;
            r_gpio_a    <= 8'h00;
            r_gpio_b    <= 8'h00;
            for (int ch = 0; ch < NUM_TONES; ch++) begin
                r_tone_count[ch] <= 12'd1;
            end
            r_tone_bit  <= 3'b000;
            r_env_count <= 16'd1;
            r_env_value <= ENV_TOP;
            r_irq       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_reg_file   <= n_reg_file;
                r_reg_index  <= n_reg_index;
                r_gpio_a     <= n_gpio_a;
                r_gpio_b     <= n_gpio_b;
                r_tone_count <= n_tone_count;
                r_tone_bit   <= n_tone_bit;
                r_env_count  <= n_env_count;
                r_env_value  <= n_env_value;
                r_irq        <= n_irq;
                r_out_valid  <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload needs no reset; it is loaded with every accepted request.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_read_data  <= n_read_data;
            r_irq_active <= n_irq;
            r_tone_out   <= n_tone_bit;
            r_env_level  <= n_env_value;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_read_data  = r_read_data;
    assign o_irq_active = r_irq_active;
    assign o_tone_a     = r_tone_out[0];
    assign o_tone_b     = r_tone_out[1];
    assign o_tone_c     = r_tone_out[2];
    assign o_env_level  = r_env_level;

endmodule

// ===== hw/rtl/psgte_checker.sv =====
module psgte_checker
    import psgte_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic [1:0] i_command,
    input logic [7:0] i_write_data,
    input logic       o_valid,
    input logic       i_ready,
    input logic [7:0] o_read_data,
    input logic       o_irq_active,
    input logic [3:0] o_env_level
);

    // A stalled result holds its payload.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_read_data) && $stable(o_env_level))
        else $error("result changed while stalled");

    // Every accepted request shows its result in the next cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> o_valid)
        else $error("accepted request produced no result");

    // An acknowledge leaves the interrupt clear.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && (i_command == CMD_ACK) |=> !o_irq_active)
        else $error("interrupt still pending after acknowledge");

    // A written byte with the top bit set raises the interrupt.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && (i_command == CMD_WRITE) && i_write_data[IRQ_DATA_BIT]
        |=> o_irq_active)
        else $error("data write did not raise the interrupt");

    // Only reads return data.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && (i_command != CMD_READ) |=> (o_read_data == 8'h00))
        else $error("non-read request returned data");

endmodule

bind psg_tone_envelope_registers psgte_checker u_psgte_checker (.*);

// ===== verif/psg_tone_envelope_checker.sv =====
`timescale 1ns / 100ps

// Watches both channels of the sound generator, keeps its own copy of the
// register file, timers and interrupt, and compares every result it sees.
module psg_tone_envelope_checker
    import psgte_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_req_valid,
    input  logic       i_req_ready,
    input  logic [1:0] i_command,
    input  logic [1:0] i_port,
    input  logic [7:0] i_write_data,
    input  logic       i_res_valid,
    input  logic       i_res_ready,
    input  logic [7:0] i_read_data,
    input  logic       i_irq_active,
    input  logic       i_tone_a,
    input  logic       i_tone_b,
    input  logic       i_tone_c,
    input  logic [3:0] i_env_level,
    output int         o_mismatches,
    output int         o_outstanding,
    output int         o_compared,
    output int         o_env_wraps
);

    typedef struct packed {
        logic [7:0] read_data;
        logic       irq_active;
        logic       tone_a;
        logic       tone_b;
        logic       tone_c;
        logic [3:0] env_level;
    } t_bus_result;

    logic [7:0]           shadow_regs [NUM_REGS];
    logic [3:0]           shadow_sel;
    logic [7:0]           shadow_gpio_a;
    logic [7:0]           shadow_gpio_b;
    logic [11:0]          tone_cnt [NUM_TONES];
    logic [NUM_TONES-1:0] tone_lvl;
    logic [15:0]          env_cnt;
    logic [3:0]           env_lvl;
    logic                 irq_flag;

    t_bus_result pending_bus_results [$];
    int          mismatches;
    int          compared;
    int          env_wraps;

    // A period of zero behaves as a period of one.
    function automatic logic [11:0] tone_reload(input int ch);
        logic [11:0] p;
        p = {shadow_regs[2*ch+1][3:0], shadow_regs[2*ch]};
        return (p == 12'd0) ? 12'd1 : p;
    endfunction

    function automatic logic [15:0] env_period();
        logic [15:0] p;
        p = {shadow_regs[REG_ENV_HI], shadow_regs[REG_ENV_LO]};
        return (p == 16'd0) ? 16'd1 : p;
    endfunction

    task automatic reload_timers();
        for (int ch = 0; ch < NUM_TONES; ch++) begin
            tone_cnt[ch] = tone_reload(ch);
            tone_lvl[ch] = 1'b0;
        end
        env_cnt = env_period();
        env_lvl = ENV_TOP;
    endtask

    task automatic clear_shadow();
        for (int r = 0; r < NUM_REGS; r++) begin
            shadow_regs[r] = 8'h00;
        end
        shadow_sel    = 4'h0;
        shadow_gpio_a = 8'h00;
        shadow_gpio_b = 8'h00;
        irq_flag      = 1'b0;
        reload_timers();
    endtask

    task automatic advance_sound_clock();
        for (int ch = 0; ch < NUM_TONES; ch++) begin
            if (tone_cnt[ch] != 12'd0) begin
                tone_cnt[ch] = tone_cnt[ch] - 12'd1;
            end
            if (tone_cnt[ch] == 12'd0) begin
                tone_lvl[ch] = ~tone_lvl[ch];
                tone_cnt[ch] = tone_reload(ch);
            end
        end
        if (env_cnt != 16'd0) begin
            env_cnt = env_cnt - 16'd1;
        end
        if (env_cnt == 16'd0) begin
            env_cnt = env_period();
            if (env_lvl != 4'd0) begin
                env_lvl = env_lvl - 4'd1;
            end else begin
                env_lvl  = ENV_TOP;
                irq_flag = 1'b1;
                env_wraps++;
            end
        end
        shadow_regs[REG_ENV_MIRROR][3:0] = env_lvl;
    endtask

    task automatic apply_bus_request(
        input  t_command    cmd,
        input  t_port       prt,
        input  logic [7:0]  data,
        output t_bus_result res
    );
        logic [7:0] rd;
        rd = 8'h00;
        case (cmd)
            CMD_READ: begin
                case (prt)
                    PORT_SELECT: rd = {4'h0, shadow_sel};
                    PORT_DATA:   rd = shadow_regs[shadow_sel];
                    PORT_GPIO_A: rd = shadow_gpio_a & shadow_regs[REG_GPIO_A_MASK];
                    default:     rd = shadow_gpio_b & shadow_regs[REG_GPIO_B_MASK];
                endcase
            end
            CMD_WRITE: begin
                case (prt)
                    PORT_SELECT: shadow_sel = data[3:0];
                    PORT_DATA: begin
                        shadow_regs[shadow_sel] = data;
                        if (shadow_sel <= REG_TONE_LAST || shadow_sel == REG_ENV_LO ||
                            shadow_sel == REG_ENV_HI) begin
                            reload_timers();
                        end
                    end
                    PORT_GPIO_A: shadow_gpio_a = data;
                    default:     shadow_gpio_b = data;
                endcase
                if (data[IRQ_DATA_BIT]) begin
                    irq_flag = 1'b1;
                end
            end
            CMD_TICK: advance_sound_clock();
            default:  irq_flag = 1'b0;
        endcase
        res.read_data  = rd;
        res.irq_active = irq_flag;
        res.tone_a     = tone_lvl[0];
        res.tone_b     = tone_lvl[1];
        res.tone_c     = tone_lvl[2];
        res.env_level  = env_lvl;
    endtask

    task automatic log_failure(input string msg);
        mismatches++;
        if (mismatches <= 10) begin
            $display("[%0t] ERROR: %s", $time, msg);
        end
    endtask

    task automatic compare_field(input string field_name, input int unsigned want_val,
                                 input int unsigned got_val);
        if (want_val !== got_val) begin
            log_failure($sformatf("result %0d field %s: expected %0h, got %0h",
                                  compared, field_name, want_val, got_val));
        end
    endtask

    always @(posedge i_clk) begin : track_bus
        t_bus_result want;
        t_bus_result got;
        if (!i_rst_n) begin
            clear_shadow();
            pending_bus_results.delete();
        end else begin
            // The result taken at this edge always belongs to an earlier request,
            // so it is checked before the request of this edge is queued.
            if (i_res_valid && i_res_ready) begin
                got.read_data  = i_read_data;
                got.irq_active = i_irq_active;
                got.tone_a     = i_tone_a;
                got.tone_b     = i_tone_b;
                got.tone_c     = i_tone_c;
                got.env_level  = i_env_level;
                if (pending_bus_results.size() == 0) begin
                    log_failure($sformatf("result with no request waiting: read_data %0h",
                                          got.read_data));
                end else begin
                    want = pending_bus_results.pop_front();
                    compare_field("read_data", 32'(want.read_data), 32'(got.read_data));
                    compare_field("irq_active", 32'(want.irq_active), 32'(got.irq_active));
                    compare_field("tone_a", 32'(want.tone_a), 32'(got.tone_a));
                    compare_field("tone_b", 32'(want.tone_b), 32'(got.tone_b));
                    compare_field("tone_c", 32'(want.tone_c), 32'(got.tone_c));
                    compare_field("env_level", 32'(want.env_level), 32'(got.env_level));
                    compared++;
                end
            end
            if (i_req_valid && i_req_ready) begin
                apply_bus_request(t_command'(i_command), t_port'(i_port), i_write_data, want);
                pending_bus_results.push_back(want);
            end
        end
        o_mismatches  <= mismatches;
        o_outstanding <= pending_bus_results.size();
        o_compared    <= compared;
        o_env_wraps   <= env_wraps;
    end

endmodule

// ===== verif/tb_psg_tone_envelope_registers.sv =====
`timescale 1ns / 100ps

// Testbench top for the sound generator register block. This module only
// produces bus requests, toggles the result-side ready, and announces the
// verdict; all prediction and comparison live in the checker instance.
module tb_psg_tone_envelope_registers;
    import psgte_pkg::*;

    // Number of requests the run aims for, directed part included, and how
    // many of the final ones run without any idling on either side.
    localparam int TOTAL_ITEMS = 1500;
    localparam int TAIL_ITEMS  = 150;
    // Length of the long result-side hold-off that forces the block to stall.
    localparam int HOLD_CYCLES = 200;
    // Cycles allowed after the last result for anything stray to show up.
    localparam int SETTLE_CYCLES = 8;
    // Generous upper bound on the whole run, far beyond the slowest legal run.
    localparam int CYCLE_LIMIT = 500000;

    // Tone period registers of channel A, used by the directed part.
    localparam logic [3:0] REG_TONE_A_LO = 4'd0;
    localparam logic [3:0] REG_TONE_A_HI = 4'd1;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    logic [1:0] i_command;
    logic [1:0] i_port;
    logic [7:0] i_write_data;
    logic       o_valid;
    logic       i_ready;
    logic [7:0] o_read_data;
    logic       o_irq_active;
    logic       o_tone_a;
    logic       o_tone_b;
    logic       o_tone_c;
    logic [3:0] o_env_level;

    int mismatches;
    int outstanding;
    int compared;
    int env_wraps;

    int requests_sent = 0;
    // Shared control between the request generator and the result sink.
    bit tail_phase    = 1'b0;
    bit sink_hold_req = 1'b0;

    psg_tone_envelope_registers u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_command     (i_command),
        .i_port        (i_port),
        .i_write_data  (i_write_data),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_read_data   (o_read_data),
        .o_irq_active  (o_irq_active),
        .o_tone_a      (o_tone_a),
        .o_tone_b      (o_tone_b),
        .o_tone_c      (o_tone_c),
        .o_env_level   (o_env_level)
    );

    psg_tone_envelope_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (i_valid),
        .i_req_ready   (o_ready),
        .i_command     (i_command),
        .i_port        (i_port),
        .i_write_data  (i_write_data),
        .i_res_valid   (o_valid),
        .i_res_ready   (i_ready),
        .i_read_data   (o_read_data),
        .i_irq_active  (o_irq_active),
        .i_tone_a      (o_tone_a),
        .i_tone_b      (o_tone_b),
        .i_tone_c      (o_tone_c),
        .i_env_level   (o_env_level),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding),
        .o_compared    (compared),
        .o_env_wraps   (env_wraps)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Offers one request and returns in the time step of the edge that takes it,
    // or later when a random gap follows. Valid stays high between back-to-back
    // requests; only a gap lowers it. The ready value read right after the edge
    // is the one that edge used, because the block's own updates land later in the same time step.
    task automatic send_request(input t_command cmd, input t_port prt, input logic [7:0] data);
        i_valid      <= 1'b1;
        i_command    <= cmd;
        i_port       <= prt;
        i_write_data <= data;
        do @(posedge i_clk); while (!o_ready);
        requests_sent++;
        if (!tail_phase && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
    endtask

    // Picks a register through the select port, then writes its data.
    task automatic write_register(input logic [3:0] reg_idx, input logic [7:0] value);
        send_request(CMD_WRITE, PORT_SELECT, {4'h0, reg_idx});
        send_request(CMD_WRITE, PORT_DATA, value);
    endtask

    // Stops offering requests until every request so far has its result back.
    // The checker's count lags the edge by one step, so the task first waits for an edge.
    task automatic wait_for_drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    // One random bus operation. Most operations are meaningful: bursts of
    // ticks so the counters actually wrap, register writes with short periods
    // so tones toggle and the envelope runs through all its levels, reads
    // of selected registers. A share of fully random requests stays as noise.
    task automatic send_random_op();
        int unsigned pick;
        logic [3:0]  reg_idx;
        logic [7:0]  value;
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            repeat ($urandom_range(1, 60)) begin
                send_request(CMD_TICK, t_port'($urandom_range(0, 3)), 8'($urandom));
            end
        end else if (pick < 52) begin
            reg_idx = 4'($urandom_range(0, NUM_REGS - 1));
            value   = 8'($urandom);
            // Mostly keep periods short; now and then let a full random byte in.
            if ($urandom_range(0, 3) != 0) begin
                if (reg_idx == REG_ENV_HI) begin
                    value = 8'h00;
                end else if (reg_idx == REG_ENV_LO ||
                             (reg_idx <= REG_TONE_LAST && !reg_idx[0])) begin
                    value = 8'($urandom_range(0, 6));
                end else if (reg_idx <= REG_TONE_LAST) begin
                    value[3:0] = 4'h0;
                end
            end
            write_register(reg_idx, value);
        end else if (pick < 67) begin
            if ($urandom_range(0, 1) == 1) begin
                send_request(CMD_WRITE, PORT_SELECT, 8'($urandom));
                send_request(CMD_READ, PORT_DATA, 8'($urandom));
            end else begin
                send_request(CMD_READ, t_port'($urandom_range(0, 3)), 8'($urandom));
            end
        end else if (pick < 75) begin
            send_request(CMD_WRITE, ($urandom_range(0, 1) == 1) ? PORT_GPIO_A : PORT_GPIO_B,
                         8'($urandom));
        end else if (pick < 82) begin
            send_request(CMD_ACK, t_port'($urandom_range(0, 3)), 8'($urandom));
        end else begin
            send_request(t_command'($urandom_range(0, 3)), t_port'($urandom_range(0, 3)),
                         8'($urandom));
        end
    endtask

    // Result sink. Ready goes low in random bursts, with runs of plain
    // readiness in between. When the generator asks for it, ready is held
    // low for a long stretch so the single result register fills and the
    // block pushes back on its request side. Each pass lowers ready when a
    // stall is due, then raises it and holds it high before the next pass.
    initial begin : result_sink
        int unsigned stall_cycles;
        i_ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            stall_cycles = 0;
            if (sink_hold_req) begin
                sink_hold_req = 1'b0;
                stall_cycles  = HOLD_CYCLES;
            end else if (!tail_phase && $urandom_range(0, 3) == 0) begin
                stall_cycles = $urandom_range(1, 14);
            end
            if (stall_cycles != 0) begin
                i_ready <= 1'b0;
                repeat (stall_cycles) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
    end

    // Safety net: if the run stalls for any reason it ends here as a failure.
    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("psg_tone_envelope_registers test failed");
        $finish;
    end

    initial begin : request_generator
        bit hold_done;
        bit drain_done;
        hold_done  = 1'b0;
        drain_done = 1'b0;

        i_rst_n      <= 1'b0;
        i_valid      <= 1'b0;
        i_command    <= CMD_READ;
        i_port       <= PORT_SELECT;
        i_write_data <= 8'h00;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset values seen through every port. Data on a read is ignored.
        send_request(CMD_READ, PORT_SELECT, 8'h00);
        send_request(CMD_READ, PORT_DATA, 8'hFF);
        send_request(CMD_READ, PORT_GPIO_A, 8'h00);
        send_request(CMD_READ, PORT_GPIO_B, 8'h00);

        // A select write keeps only its low nibble; bit 7 of the byte still
        // raises the interrupt, and the acknowledge clears it again.
        send_request(CMD_WRITE, PORT_SELECT, 8'hF8);
        send_request(CMD_READ, PORT_SELECT, 8'h00);
        send_request(CMD_ACK, PORT_SELECT, 8'h00);

        // With all periods zero every tick toggles the tones and steps the
        // envelope; the selected register 8 mirrors the envelope level while
        // a written high nibble survives the next tick.
        send_request(CMD_TICK, PORT_DATA, 8'h00);
        send_request(CMD_READ, PORT_DATA, 8'h00);
        send_request(CMD_WRITE, PORT_DATA, 8'hA0);
        send_request(CMD_TICK, PORT_GPIO_B, 8'hFF);
        send_request(CMD_READ, PORT_DATA, 8'h00);

        // GPIO reads are the latches masked by registers 14 and 15.
        send_request(CMD_WRITE, PORT_GPIO_A, 8'hFF);
        send_request(CMD_WRITE, PORT_GPIO_B, 8'h5A);
        write_register(REG_GPIO_A_MASK, 8'h3C);
        write_register(REG_GPIO_B_MASK, 8'hFF);
        send_request(CMD_READ, PORT_GPIO_A, 8'h00);
        send_request(CMD_READ, PORT_GPIO_B, 8'h00);

        // Timer restart through the longest tone period and a large envelope
        // period; channels B and C keep period zero and toggle on each tick.
        write_register(REG_TONE_A_LO, 8'hFF);
        write_register(REG_TONE_A_HI, 8'hFF);
        write_register(REG_ENV_HI, 8'hFF);
        send_request(CMD_TICK, PORT_SELECT, 8'h00);
        send_request(CMD_TICK, PORT_SELECT, 8'h00);
        send_request(CMD_ACK, PORT_DATA, 8'h00);

        // Let everything come back before the random part starts.
        wait_for_drain();

        while (requests_sent < TOTAL_ITEMS) begin
            // Partway in, the sink holds off for a long time while requests
            // keep coming; later the generator itself waits for a full drain.
            if (!hold_done && requests_sent >= TOTAL_ITEMS / 3) begin
                hold_done     = 1'b1;
                sink_hold_req = 1'b1;
            end
            if (!drain_done && requests_sent >= (2 * TOTAL_ITEMS) / 3) begin
                drain_done = 1'b1;
                wait_for_drain();
            end
            tail_phase = (requests_sent >= TOTAL_ITEMS - TAIL_ITEMS);
            send_random_op();
        end

        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Sent %0d bus requests (reads, writes, ticks, acknowledges and noise);",
                 requests_sent);
        $display("checked %0d results, envelope wrapped %0d times, %0d mismatches.",
                 compared, env_wraps, mismatches);
        if (mismatches == 0 && outstanding == 0) begin
            $display("psg_tone_envelope_registers test passed");
        end else begin
            $display("psg_tone_envelope_registers test failed");
        end
        $finish;
    end

endmodule
